/* sv/skt_pkg.sv */
// Types, codes and helpers shared by the sorted key table files.
package skt_pkg;

    localparam int KEY_W = 30;
    localparam int IDX_W = 16;
    localparam int ST_W  = 2;

    // Operation carried by a word as it walks down the cell chain.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DROP   = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [ST_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_FOUND    = 2'd2;
    localparam logic [ST_W-1:0] ST_MISSING  = 2'd3;

    localparam logic ACT_INSERT = 1'b0;

    typedef struct packed {
        logic [1:0]       op;
        logic             live;   // insert still carries a record to place
        logic             shift;  // insert has displaced a record and pushes the rest down
        logic             hit;    // search has matched a record
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;    // carried index, or matched index on search
    } t_tok;

    function automatic logic [ST_W-1:0] f_status(input logic [1:0] op, input logic hit);
        logic [ST_W-1:0] st;
        case (op)
            OP_INSERT: st = ST_INSERTED;
            OP_DROP:   st = ST_FULL;
            OP_SEARCH: st = hit ? ST_FOUND : ST_MISSING;
            default:   st = ST_MISSING;
        endcase
        return st;
    endfunction

endpackage

/* sv/skt_in_if.sv */
// Input channel of the sorted key table: insert or search requests.
interface skt_in_if import skt_pkg::*; ;
    logic             valid;
    logic             ready;
    logic             action;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] entry_index;

    modport source(output valid, action, key, entry_index, input ready);
    modport sink(input valid, action, key, entry_index, output ready);
endinterface

/* sv/skt_out_if.sv */
// Output channel of the sorted key table: one result per request.
interface skt_out_if import skt_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] found_index;

    modport source(output valid, status, found_index, input ready);
    modport sink(input valid, status, found_index, output ready);
endinterface

/* sv/sorted_key_table_insert_search_unit.sv */
// Sorted key table: a chain of CAPACITY cells that request words walk through.
// An accepted request passes through the word registers of all CAPACITY cells, in chain order, to the output.
// Throughput: one request per cycle; the whole chain holds while a result is stalled.
// The last cell's word register is the output register.
// Reset empties the table at once (valid bit per cell) and clears the record count.
module sorted_key_table_insert_search_unit import skt_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    skt_in_if.sink     i_in,
    skt_out_if.source  o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_adv;
    logic             w_accept;
    logic             w_full;
    t_tok             w_head;
    logic             w_valid [0:CAPACITY];
    t_tok             w_tok   [0:CAPACITY];

    assign w_adv    = !w_valid[CAPACITY] || o_out.ready;
    assign w_accept = i_in.valid && w_adv;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign i_in.ready = w_adv;

    // Fullness is settled at entry, so an insert that goes in always finds a free cell.
    always_comb begin
        n_count      = r_count;
        w_head.op    = OP_SEARCH;
        w_head.live  = 1'b0;
        w_head.shift = 1'b0;
        w_head.hit   = 1'b0;
        w_head.key   = i_in.key;
        w_head.idx   = '0;
        if (i_in.action == ACT_INSERT) begin
            w_head.idx = i_in.entry_index;
            if (w_full) begin
                w_head.op = OP_DROP;
            end else begin
                w_head.op   = OP_INSERT;
                w_head.live = 1'b1;
                n_count     = r_count + CNT_W'(1);
            end
        end
    end
    assign w_tok[0]   = w_head;
    assign w_valid[0] = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        skt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_adv       (w_adv),
            .i_tok_valid (w_valid[g]),
            .i_tok       (w_tok[g]),
            .o_tok_valid (w_valid[g+1]),
            .o_tok       (w_tok[g+1])
        );
    end

    assign o_out.valid       = w_valid[CAPACITY];
    assign o_out.status      = f_status(w_tok[CAPACITY].op, w_tok[CAPACITY].hit);
    assign o_out.found_index = (w_tok[CAPACITY].op == OP_SEARCH && w_tok[CAPACITY].hit) ?
                               w_tok[CAPACITY].idx : '0;

endmodule

/* sv/skt_cell.sv */
// One cell of the sorted chain: holds a record and processes the passing word.
module skt_cell import skt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  logic i_tok_valid,
    input  t_tok i_tok,
    output logic o_tok_valid,
    output t_tok o_tok
);

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [IDX_W-1:0] r_idx;
    logic             r_tok_valid;
    t_tok             r_tok;

    logic             n_valid;
    logic [KEY_W-1:0] n_key;
    logic [IDX_W-1:0] n_idx;
    t_tok             n_tok;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_idx   = r_idx;
        n_tok   = i_tok;
        if (i_tok_valid) begin
            case (i_tok.op)
                OP_INSERT: begin
                    if (i_tok.live) begin
                        if (!r_valid) begin
                            // First empty cell takes the record for good.
                            n_valid    = 1'b1;
                            n_key      = i_tok.key;
                            n_idx      = i_tok.idx;
                            n_tok.live = 1'b0;
                        end else if (i_tok.shift || (r_key > i_tok.key)) begin
                            // Swap: the displaced record moves one cell down, and every
                            // record after it follows, equal keys included.
                            n_key       = i_tok.key;
                            n_idx       = i_tok.idx;
                            n_tok.key   = r_key;
                            n_tok.idx   = r_idx;
                            n_tok.shift = 1'b1;
                        end
                    end
                end
                OP_SEARCH: begin
                    if (r_valid && !i_tok.hit && (r_key == i_tok.key)) begin
                        n_tok.hit = 1'b1;
                        n_tok.idx = r_idx;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_tok_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid     <= n_valid;
            r_tok_valid <= i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_key <= n_key;
            r_idx <= n_idx;
            r_tok <= n_tok;
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

endmodule

/* sv/skt_checker.sv */
// Port checker for the sorted key table, bound to the top level.
module skt_checker import skt_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [ST_W-1:0]  i_status,
    input logic [IDX_W-1:0] i_found_index
);

    // A stalled result keeps its status.
    a_hold_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status))
        else $error("result status changed while stalled");

    // Only a found search carries a nonzero index.
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_FOUND |-> i_found_index == '0)
        else $error("nonzero index without a match");

    // The chain takes a request whenever its output is free or draining.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready disagrees with output state");

    // Nothing comes out in the cycle right after a reset cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

endmodule

bind sorted_key_table_insert_search_unit skt_checker u_skt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_found_index (o_out.found_index)
);
